>>> rtl/core/rpa_pkg.sv
// Shared types, widths and codes of the per-requester page allocator.
package rpa_pkg;

	localparam int REQUESTERS = 8;
	localparam int REQ_W      = $clog2(REQUESTERS);
	localparam int PAGES      = 32768;
	localparam int PAGE_W     = $clog2(PAGES);
	localparam int LIMIT_W    = PAGE_W + 1;
	localparam int CFG_W      = LIMIT_W;
	localparam int LINK_W     = PAGE_W + 1;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic CFG_FIRST = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(PAGES);

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

	typedef struct packed {
		logic             found;
		logic [REQ_W-1:0] idx;
	} pick_t;

endpackage

>>> rtl/core/rpa_link_ram.sv
// Synchronous link store: one write port, one read port, registered read data.
module rpa_link_ram #(
	parameter int ADDR_W = 15,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/rpa_pick.sv
// List picker: own list if it holds a page, else the lowest-numbered non-empty list.
module rpa_pick (
	input  logic [rpa_pkg::REQUESTERS-1:0] nonempty,
	input  logic [rpa_pkg::REQ_W-1:0]      own,
	output rpa_pkg::pick_t                 pick
);

	logic                      low_found;
	logic [rpa_pkg::REQ_W-1:0] low_idx;

	// own list is empty when we fall through, so the lowest set bit is another list
	always_comb begin
		low_found = 1'b0;
		low_idx   = '0;
		for (int i = rpa_pkg::REQUESTERS - 1; i >= 0; i--) begin
			if (nonempty[i]) begin
				low_found = 1'b1;
				low_idx   = rpa_pkg::REQ_W'(i);
			end
		end
	end

	always_comb begin
		if (nonempty[own]) begin
			pick.found = 1'b1;
			pick.idx   = own;
		end else begin
			pick.found = low_found;
			pick.idx   = low_idx;
		end
	end

endmodule

>>> rtl/core/per_requester_page_allocator_top.sv
// Per-requester page allocator: one LIFO free list per requester, with stealing.
// A request is taken when start is high and busy is low. A free, or an allocate
// that finds every list empty, is answered in the next cycle and leaves the block
// ready again at once; an allocate that finds a page passes through ST_POP,
// because the next link of the popped page comes out of the synchronous link
// memory in the cycle after its address, and busy is high in ST_POP. Each result
// shows for exactly one cycle with done high and cannot be held off by the
// receiver. Configuration writes (cfg_wr_en, cfg_idx, cfg_wdata) take effect at
// once and belong only to idle periods.
module per_requester_page_allocator_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_idx,
	input  logic [rpa_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         start,
	output logic                         busy,
	input  logic                         opcode,
	input  logic [rpa_pkg::REQ_W-1:0]    requester,
	input  logic [rpa_pkg::PAGE_W-1:0]   page_index,
	output logic                         done,
	output logic [rpa_pkg::PAGE_W-1:0]   granted_page,
	output logic [1:0]                   status
);

	rpa_pkg::state_t state_q, state_nxt;

	logic [rpa_pkg::PAGE_W-1:0]     first_q;
	logic [rpa_pkg::LIMIT_W-1:0]    limit_q;
	logic [rpa_pkg::PAGE_W-1:0]     head_q [rpa_pkg::REQUESTERS];
	logic [rpa_pkg::REQUESTERS-1:0] nonempty_q;
	logic [rpa_pkg::REQ_W-1:0]      pop_who_q;
	logic [rpa_pkg::PAGE_W-1:0]     top_q;
	logic                           done_q;
	logic [rpa_pkg::PAGE_W-1:0]     granted_q;
	logic [1:0]                     status_q;

	rpa_pkg::pick_t               pick;
	logic                         accept;
	logic                         in_range;
	logic                         push;
	logic                         pop_rd;
	logic [rpa_pkg::LINK_W-1:0]   link_wdata;
	logic [rpa_pkg::LINK_W-1:0]   link_rdata;
	logic [rpa_pkg::PAGE_W-1:0]   pick_head;

	assign accept    = start && !busy;
	assign in_range  = (page_index >= first_q) &&
		({1'b0, page_index} < limit_q);
	assign push      = accept && (opcode == rpa_pkg::OP_FREE) && in_range;
	assign pop_rd    = accept && (opcode == rpa_pkg::OP_ALLOC) && pick.found;
	assign pick_head = head_q[pick.idx];
	// link entry: top bit says the page below is real
	assign link_wdata = {nonempty_q[requester], head_q[requester]};

	rpa_pick u_pick (
		.nonempty (nonempty_q),
		.own      (requester),
		.pick     (pick)
	);

	rpa_link_ram #(
		.ADDR_W (rpa_pkg::PAGE_W),
		.DATA_W (rpa_pkg::LINK_W)
	) u_link_ram (
		.clk   (clk),
		.we    (push),
		.waddr (page_index),
		.wdata (link_wdata),
		.re    (pop_rd),
		.raddr (pick_head),
		.rdata (link_rdata)
	);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rpa_pkg::ST_IDLE: begin
				if (pop_rd) begin
					state_nxt = rpa_pkg::ST_POP;
				end
			end
			rpa_pkg::ST_POP: begin
				state_nxt = rpa_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = rpa_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			rpa_pkg::ST_IDLE: busy = 1'b0;
			rpa_pkg::ST_POP:  busy = 1'b1;
			default:          busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpa_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			limit_q <= rpa_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				rpa_pkg::CFG_FIRST: first_q <= cfg_wdata[rpa_pkg::PAGE_W-1:0];
				rpa_pkg::CFG_LIMIT: limit_q <= cfg_wdata;
				default:            ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rpa_pkg::REQUESTERS; i++) begin
				head_q[i] <= '0;
			end
			nonempty_q <= '0;
		end else if (state_q == rpa_pkg::ST_POP) begin
			head_q[pop_who_q]     <= link_rdata[rpa_pkg::PAGE_W-1:0];
			nonempty_q[pop_who_q] <= link_rdata[rpa_pkg::PAGE_W];
		end else if (push) begin
			head_q[requester]     <= page_index;
			nonempty_q[requester] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_rd) begin
			pop_who_q <= pick.idx;
			top_q     <= pick_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && !pop_rd) || (state_q == rpa_pkg::ST_POP);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rpa_pkg::ST_POP) begin
			granted_q <= top_q;
			status_q  <= rpa_pkg::STAT_DONE;
		end else if (accept) begin
			granted_q <= '0;
			if (opcode == rpa_pkg::OP_FREE) begin
				status_q <= in_range ? rpa_pkg::STAT_DONE : rpa_pkg::STAT_RANGE;
			end else begin
				status_q <= rpa_pkg::STAT_EMPTY;
			end
		end
	end

	assign done         = done_q;
	assign granted_page = granted_q;
	assign status       = status_q;

endmodule

>>> test/tb_per_requester_page_allocator_top.sv
// Testbench for the per-requester page allocator: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module tb_per_requester_page_allocator_top;
	import rpa_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [1:0]        stat;
	} alloc_result_t;

	// Tracks every free list and the queue of results still owed by the block.
	class page_alloc_scoreboard;
		logic [PAGE_W-1:0] link_mem [PAGES];
		bit                link_ok  [PAGES];
		logic [PAGE_W-1:0] head     [REQUESTERS];
		bit                nonempty [REQUESTERS];
		logic [PAGE_W-1:0] first_pg;
		logic [LIMIT_W-1:0] limit_pg;
		alloc_result_t     pending [$];
		int errors;
		int checked;
		int granted;
		int empties;
		int rejected;

		function new();
			for (int w = 0; w < REQUESTERS; w++) begin
				head[w] = '0;
				nonempty[w] = 1'b0;
			end
			first_pg = '0;
			limit_pg = LIMIT_RESET;
			errors = 0;
			checked = 0;
			granted = 0;
			empties = 0;
			rejected = 0;
		endfunction

		function void set_reg(logic idx, logic [CFG_W-1:0] val);
			if (idx == CFG_FIRST)
				first_pg = val[PAGE_W-1:0];
			else
				limit_pg = val[LIMIT_W-1:0];
		endfunction

		// Applies one accepted request and queues the result it must produce.
		function alloc_result_t note_request(logic op, logic [REQ_W-1:0] who,
				logic [PAGE_W-1:0] page);
			alloc_result_t res;
			int victim;
			res.page = '0;
			res.stat = STAT_DONE;
			victim = -1;
			if (op == OP_FREE) begin
				if (page < first_pg || {1'b0, page} >= limit_pg) begin
					res.stat = STAT_RANGE;
				end else begin
					link_mem[page] = head[who];
					link_ok[page] = nonempty[who];
					head[who] = page;
					nonempty[who] = 1'b1;
				end
			end else begin
				if (nonempty[who])
					victim = int'(who);
				else
					// steal from the lowest-numbered other list
					for (int w = 0; w < REQUESTERS; w++)
						if (victim < 0 && w != int'(who) && nonempty[w])
							victim = w;
				if (victim < 0) begin
					res.stat = STAT_EMPTY;
				end else begin
					res.page = head[victim];
					head[victim] = link_mem[res.page];
					nonempty[victim] = link_ok[res.page];
					granted++;
				end
			end
			pending.push_back(res);
			return res;
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("ERROR at %0t: %s", $time, msg);
		endtask

		task check_result(logic [PAGE_W-1:0] pg, logic [1:0] st);
			alloc_result_t want;
			if (pending.size() == 0) begin
				report($sformatf("result with none pending: page %0d status %0d", pg, st));
				return;
			end
			want = pending.pop_front();
			checked++;
			if (pg !== want.page)
				report($sformatf("granted_page %0d, expected %0d", pg, want.page));
			if (st !== want.stat)
				report($sformatf("status %0d, expected %0d", st, want.stat));
			case (want.stat)
				STAT_EMPTY: empties++;
				STAT_RANGE: rejected++;
				default:    ;
			endcase
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic                cfg_idx;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                start;
	logic                busy;
	logic                opcode;
	logic [REQ_W-1:0]    requester;
	logic [PAGE_W-1:0]   page_index;
	logic                done;
	logic [PAGE_W-1:0]   granted_page;
	logic [1:0]          status;

	page_alloc_scoreboard sb = new();

	// stimulus-side view: pages sitting on some list, pages handed out
	bit                page_listed [PAGES];
	logic [PAGE_W-1:0] held_pages [$];
	logic [PAGE_W-1:0] win_first;
	logic [LIMIT_W-1:0] win_limit;
	int settings;
	int cycles;

	per_requester_page_allocator_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.requester   (requester),
		.page_index  (page_index),
		.done        (done),
		.granted_page(granted_page),
		.status      (status)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending", cycles,
				sb.pending.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Outputs and the handshake are sampled mid-cycle, where they are settled.
	always @(negedge clk) begin
		alloc_result_t exp_res;
		if (arst_n) begin
			if (done)
				sb.check_result(granted_page, status);
			if (start && !busy) begin
				exp_res = sb.note_request(opcode, requester, page_index);
				if (exp_res.stat == STAT_DONE) begin
					if (opcode == OP_FREE) begin
						page_listed[page_index] = 1'b1;
					end else begin
						page_listed[exp_res.page] = 1'b0;
						held_pages.push_back(exp_res.page);
					end
				end
			end
		end
	end

	function automatic bit in_window(logic [PAGE_W-1:0] page);
		return page >= win_first && {1'b0, page} < win_limit;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Returns at the edge that accepted the request.
	task automatic send_request(logic op, logic [REQ_W-1:0] who, logic [PAGE_W-1:0] page);
		start <= 1'b1;
		opcode <= op;
		requester <= who;
		page_index <= page;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		sb.set_reg(idx, val);
		if (idx == CFG_FIRST)
			win_first = val[PAGE_W-1:0];
		else
			win_limit = val[LIMIT_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_window(logic [CFG_W-1:0] first_val, logic [CFG_W-1:0] limit_val);
		wait_idle();
		write_reg(CFG_FIRST, first_val);
		write_reg(CFG_LIMIT, limit_val);
		settings++;
	endtask

	task automatic run_directed();
		send_request(OP_ALLOC, 3'd0, '0);        // nothing anywhere
		send_request(OP_ALLOC, 3'd7, 15'h7FFF);
		send_request(OP_FREE, 3'd0, 15'h0000);
		send_request(OP_FREE, 3'd7, 15'h7FFF);
		send_request(OP_FREE, 3'd3, 15'h5555);
		send_request(OP_FREE, 3'd3, 15'h2AAA);
		send_request(OP_ALLOC, 3'd3, 15'h1234);  // own list, last in first out
		send_request(OP_ALLOC, 3'd5, '0);        // steals from list 0
		send_request(OP_ALLOC, 3'd5, '0);        // steals from list 3
		send_request(OP_ALLOC, 3'd1, '0);        // steals from list 7
		send_request(OP_ALLOC, 3'd6, 15'h7FFF);
		// same page freed onto two lists: handed out twice
		send_request(OP_FREE, 3'd1, 15'd200);
		send_request(OP_FREE, 3'd4, 15'd200);
		send_request(OP_ALLOC, 3'd4, '0);
		send_request(OP_ALLOC, 3'd1, '0);
		send_request(OP_ALLOC, 3'd1, '0);
		pause(pick_gap());
	endtask

	task automatic run_random(int count);
		int alloc_pct;
		bit gappy;
		int r;
		int hi;
		int sel;
		logic op;
		logic [PAGE_W-1:0] page;
		logic [LIMIT_W:0] edge_val;
		alloc_pct = 50;
		gappy = 1'b1;
		for (int k = 0; k < count; k++) begin
			if (k % 20 == 0) begin
				r = $urandom_range(2);
				alloc_pct = (r == 0) ? 15 : (r == 1) ? 50 : 85;
				gappy = $urandom_range(2) != 0;
			end
			page = PAGE_W'($urandom_range(PAGES - 1));
			op = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE;
			if (op == OP_FREE) begin
				r = $urandom_range(99);
				hi = (win_limit > PAGES) ? PAGES : int'(win_limit);
				if (r < 55 && held_pages.size() > 0) begin
					sel = $urandom_range(held_pages.size() - 1);
					page = held_pages[sel];
					held_pages.delete(sel);
				end else if (r < 90) begin
					if (hi > int'(win_first))
						page = PAGE_W'($urandom_range(int'(win_first), hi - 1));
				end else if (r < 96) begin
					// probe just inside and just outside the window
					case ($urandom_range(3))
						0:       edge_val = {2'b0, win_first} - 17'd1;
						1:       edge_val = {2'b0, win_first};
						2:       edge_val = {1'b0, win_limit} - 17'd1;
						default: edge_val = {1'b0, win_limit};
					endcase
					page = edge_val[PAGE_W-1:0];
				end
				// a second free of a listed page would tie the lists into a loop
				if (in_window(page) && page_listed[page])
					op = OP_ALLOC;
			end
			send_request(op, REQ_W'($urandom_range(REQUESTERS - 1)), page);
			if (gappy)
				pause(pick_gap());
		end
	endtask

	initial begin
		logic [PAGE_W-1:0] mid_first;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_idx <= CFG_FIRST;
		cfg_wdata <= '0;
		start <= 1'b0;
		opcode <= OP_ALLOC;
		requester <= '0;
		page_index <= '0;
		cycles = 0;
		settings = 1;
		win_first = '0;
		win_limit = LIMIT_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random(110);

		set_window(16'd0, 16'd1);               // only page 0 usable
		run_random(105);
		set_window(16'hFFFF, 16'hFFFF);         // upper bit of first dropped: only top page
		run_random(105);
		set_window(16'd100, 16'd50);            // empty window
		run_random(105);
		set_window(16'd0, 16'd0);
		run_random(105);
		mid_first = PAGE_W'($urandom_range(20000));
		set_window({1'b0, mid_first}, 16'({1'b0, mid_first}) + 16'($urandom_range(1, 12000)));
		run_random(105);
		set_window(16'd0, 16'(PAGES));
		run_random(105);

		wait_idle();
		repeat (10) @(posedge clk);
		$display("Checked %0d results: %0d pages granted, %0d allocates found no page,",
			sb.checked, sb.granted, sb.empties);
		$display("%0d frees rejected out of range, over %0d window settings",
			sb.rejected, settings);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
